>>> hw/rtl/ple_pkg.sv
// Shared types, codes and field layout for the positional list engine.
`default_nettype none

package ple_pkg;

  localparam int unsigned TypeW    = 2;
  localparam int unsigned PosW     = 7;
  localparam int unsigned WordW    = 32;
  localparam int unsigned StatW    = 2;
  localparam int unsigned CntOutW  = 7;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 48;
  localparam int unsigned GroupN   = 32;

  typedef enum logic [TypeW-1:0] {
    REQ_READ      = 2'd0,
    REQ_OVERWRITE = 2'd1,
    REQ_INSERT    = 2'd2,
    REQ_REMOVE    = 2'd3
  } req_e;

  typedef enum logic [StatW-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic            rd;
    logic            wr;
    logic            ins;
    logic            rem;
    logic [PosW-1:0] idx;
  } ctrl_t;

endpackage

`default_nettype wire

>>> hw/rtl/ple_cell.sv
// One storage cell of the list chain: holds a word and shifts with its neighbors.
`default_nettype none

module ple_cell #(
  parameter int unsigned IDX = 0
) (
  input  wire logic                       clk_i,
  input  wire ple_pkg::ctrl_t             ctrl_i,
  input  wire logic [ple_pkg::WordW-1:0]  word_i,
  input  wire logic [ple_pkg::WordW-1:0]  prev_i,
  input  wire logic [ple_pkg::WordW-1:0]  next_i,
  output logic      [ple_pkg::WordW-1:0]  word_o,
  output logic      [ple_pkg::WordW-1:0]  tap_o
);
  import ple_pkg::*;

  logic [WordW-1:0] word_q, word_d;
  logic [31:0]      idx_x;
  logic             hit;
  logic             above;

  assign idx_x = 32'(ctrl_i.idx);
  assign hit   = (idx_x == IDX);
  assign above = (idx_x < IDX);

  always_comb begin
    word_d = word_q;
    if ((ctrl_i.wr || ctrl_i.ins) && hit) begin
      word_d = word_i;
    end else if (ctrl_i.ins && above) begin
      word_d = prev_i;
    end else if (ctrl_i.rem && (hit || above)) begin
      word_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;
  assign tap_o  = (ctrl_i.rd && hit) ? word_q : '0;

endmodule

`default_nettype wire

>>> hw/rtl/ple_orgrp.sv
// Registered OR merge of one group of cell read taps.
`default_nettype none

module ple_orgrp #(
  parameter int unsigned N = 32
) (
  input  wire logic                              clk_i,
  input  wire logic                              en_i,
  input  wire logic [N-1:0][ple_pkg::WordW-1:0]  taps_i,
  output logic      [ple_pkg::WordW-1:0]         or_o
);
  import ple_pkg::*;

  logic [WordW-1:0] or_q, or_d;

  always_comb begin
    or_d = '0;
    for (int unsigned i = 0; i < N; i++) begin
      or_d = or_d | taps_i[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      or_q <= or_d;
    end
  end

  assign or_o = or_q;

endmodule

`default_nettype wire

>>> hw/rtl/positional_list_engine_unit.sv
// Top level of the positional list engine: cell chain, read merge and result stages.
//
//  channel  dir  handshake                     tdata (low bit up)
//  s_axis   in   s_axis_tvalid/s_axis_tready   req_type, position, word_in
//  m_axis   out  m_axis_tvalid/m_axis_tready   read_word, status, entry_count, is_empty
//
// One request per cycle while s_axis_tready is high; each result is registered in stage 1, then in stage 2.
// Overwrite loads the addressed cell; insert and remove shift the cells from the position on at the transfer edge.
// Reads merge the cell taps through a registered group OR, then a final OR.
// Reset clears the count and the stage valids; cell contents are not cleared.
// A stalled output holds both stages; input stalls only when they are full.
`default_nettype none

module positional_list_engine_unit #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // req_type[1:0], position[8:2], word_in[40:9], zero fill
  input  wire logic [ple_pkg::InDataW-1:0]    s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // read_word[31:0], status[33:32], entry_count[40:34], is_empty[41], zero fill
  output logic      [ple_pkg::OutDataW-1:0]   m_axis_tdata
);
  import ple_pkg::*;

  localparam int unsigned CntW   = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW   = ((CntW > PosW) ? CntW : PosW) + 1;
  localparam int unsigned NGroup = (CAPACITY + GroupN - 1) / GroupN;
  localparam int unsigned TapN   = NGroup * GroupN;

  logic [TypeW-1:0] req_raw;
  req_e             req;
  logic [PosW-1:0]  pos;
  logic [WordW-1:0] word_in;

  assign req_raw = s_axis_tdata[TypeW-1:0];
  assign req     = req_e'(req_raw);
  assign pos     = s_axis_tdata[TypeW +: PosW];
  assign word_in = s_axis_tdata[TypeW+PosW +: WordW];

  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             s1_valid_q, s1_valid_d;
  status_e          s1_status_q;
  logic [CntOutW-1:0] s1_cnt_q;
  logic             s1_empty_q;
  logic             s1_err_q;
  logic             s2_valid_q, s2_valid_d;
  logic [OutDataW-1:0] s2_data_q;

  logic             accept;
  logic             s2_adv;
  logic [CmpW-1:0]  pos_x, cnt_x;
  logic             bad_pos;
  logic             full;
  status_e          status;
  logic             rd_err;
  ctrl_t            ctrl;

  assign s2_adv        = s1_valid_q && (!s2_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s2_adv;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign pos_x = CmpW'(pos);
  assign cnt_x = CmpW'(cnt_q);

  always_comb begin
    bad_pos = 1'b0;
    full    = 1'b0;
    status  = ST_DONE;
    rd_err  = 1'b0;
    cnt_d   = cnt_q;
    ctrl    = '0;
    ctrl.idx = pos - PosW'(1);
    case (req)
      REQ_INSERT: begin
        bad_pos = (pos == '0) || (pos_x > cnt_x + CmpW'(1));
        full    = (cnt_x == CmpW'(CAPACITY));
      end
      default: begin
        bad_pos = (pos == '0) || (pos_x > cnt_x);
      end
    endcase
    if (bad_pos) begin
      status = ST_RANGE;
      rd_err = (req == REQ_READ);
    end else if (full) begin
      status = ST_FULL;
    end else if (accept) begin
      case (req)
        REQ_READ:      ctrl.rd = 1'b1;
        REQ_OVERWRITE: ctrl.wr = 1'b1;
        REQ_INSERT: begin
          ctrl.ins = 1'b1;
          cnt_d    = cnt_q + CntW'(1);
        end
        REQ_REMOVE: begin
          ctrl.rem = 1'b1;
          cnt_d    = cnt_q - CntW'(1);
        end
        default: ;
      endcase
    end
  end

  logic [CAPACITY-1:0][WordW-1:0] words;
  logic [TapN-1:0][WordW-1:0]     taps;
  logic [NGroup-1:0][WordW-1:0]   grp;

  for (genvar c = 0; c < TapN; c++) begin : g_cell
    if (c < CAPACITY) begin : g_real
      logic [WordW-1:0] prev_w, next_w;
      if (c == 0) begin : g_first
        assign prev_w = '0;
      end else begin : g_mid_p
        assign prev_w = words[c-1];
      end
      if (c == CAPACITY - 1) begin : g_last
        assign next_w = '0;
      end else begin : g_mid_n
        assign next_w = words[c+1];
      end
      ple_cell #(
        .IDX (c)
      ) u_cell (
        .clk_i  (clk_i),
        .ctrl_i (ctrl),
        .word_i (word_in),
        .prev_i (prev_w),
        .next_i (next_w),
        .word_o (words[c]),
        .tap_o  (taps[c])
      );
    end else begin : g_pad
      assign taps[c] = '0;
    end
  end

  for (genvar g = 0; g < NGroup; g++) begin : g_grp
    ple_orgrp #(
      .N (GroupN)
    ) u_orgrp (
      .clk_i  (clk_i),
      .en_i   (accept),
      .taps_i (taps[g*GroupN +: GroupN]),
      .or_o   (grp[g])
    );
  end

  logic [WordW-1:0] rd_word;

  always_comb begin
    rd_word = '0;
    for (int unsigned g = 0; g < NGroup; g++) begin
      rd_word = rd_word | grp[g];
    end
    if (s1_err_q) begin
      rd_word = '1;
    end
  end

  assign s1_valid_d = accept || (s1_valid_q && !s2_adv);
  assign s2_valid_d = s2_adv || (s2_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      cnt_q      <= cnt_d;
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_status_q <= status;
      s1_cnt_q    <= CntOutW'(cnt_d);
      s1_empty_q  <= (cnt_d == '0);
      s1_err_q    <= rd_err;
    end
    if (s2_adv) begin
      s2_data_q <= OutDataW'({s1_empty_q, s1_cnt_q, s1_status_q, rd_word});
    end
  end

  assign m_axis_tvalid = s2_valid_q;
  assign m_axis_tdata  = s2_data_q;

endmodule

`default_nettype wire

>>> hw/rtl/ple_checker.sv
// Port-level checks for the positional list engine, bound to its top level.
`default_nettype none

module ple_checker #(
  parameter int unsigned CAPACITY = 64
) (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          s_axis_tvalid,
  input wire logic                          s_axis_tready,
  input wire logic [ple_pkg::InDataW-1:0]   s_axis_tdata,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [ple_pkg::OutDataW-1:0]  m_axis_tdata
);
  import ple_pkg::*;

  logic [WordW-1:0]   o_word;
  logic [StatW-1:0]   o_stat;
  logic [CntOutW-1:0] o_cnt;
  logic               o_empty;

  assign o_word  = m_axis_tdata[WordW-1:0];
  assign o_stat  = m_axis_tdata[WordW +: StatW];
  assign o_cnt   = m_axis_tdata[WordW+StatW +: CntOutW];
  assign o_empty = m_axis_tdata[WordW+StatW+CntOutW];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (CAPACITY < 128) |-> (o_empty == (o_cnt == '0)))
    else $error("empty flag disagrees with count");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (o_stat == ST_DONE || o_stat == ST_RANGE || o_stat == ST_FULL))
    else $error("undefined status code");

  a_fail_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && o_stat != ST_DONE |-> (o_word == '0 || o_word == '1))
    else $error("failed request carries a data word");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && o_stat == ST_FULL |-> (o_cnt == CntOutW'(CAPACITY)))
    else $error("full reported below capacity");

endmodule

bind positional_list_engine_unit ple_checker #(
  .CAPACITY (CAPACITY)
) u_ple_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

>>> dv/ple_list_checker.sv
// Checker for the positional list engine: list predictor and result comparison.
`timescale 1ns / 1ps

module ple_list_checker #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  input  logic                         s_axis_tready,
  input  logic [ple_pkg::InDataW-1:0]  s_axis_tdata,
  input  logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  input  logic [ple_pkg::OutDataW-1:0] m_axis_tdata,
  output int                           fail_count_o,
  output int                           pending_count_o,
  output int                           result_count_o
);
  import ple_pkg::*;

  typedef struct packed {
    logic               is_empty;
    logic [CntOutW-1:0] entry_count;
    status_e            status;
    logic [WordW-1:0]   read_word;
  } list_result_t;

  logic [WordW-1:0] list_words [CAPACITY];
  int unsigned      list_len;
  list_result_t     expected_results [$];

  initial begin
    fail_count_o    = 0;
    pending_count_o = 0;
    result_count_o  = 0;
  end

  task automatic report_mismatch(input string field, input logic [WordW-1:0] got,
                                 input logic [WordW-1:0] want);
    $display("[%0t] result %0d: %s is %0h, want %0h", $realtime, result_count_o, field,
             got, want);
    fail_count_o++;
  endtask

  task automatic apply_list_request(input req_e kind, input logic [PosW-1:0] pos,
                                    input logic [WordW-1:0] word);
    list_result_t res;
    int unsigned  p;
    int           i;
    res        = '0;
    res.status = ST_DONE;
    p          = pos;
    if (kind == REQ_INSERT) begin
      if (p < 1 || p > list_len + 1) begin
        res.status = ST_RANGE;
      end else if (list_len >= CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        for (i = list_len; i >= int'(p); i--) list_words[i] = list_words[i-1];
        list_words[p-1] = word;
        list_len++;
      end
    end else if (p < 1 || p > list_len) begin
      res.status = ST_RANGE;
      if (kind == REQ_READ) res.read_word = '1;
    end else if (kind == REQ_READ) begin
      res.read_word = list_words[p-1];
    end else if (kind == REQ_OVERWRITE) begin
      list_words[p-1] = word;
    end else begin
      for (i = p; i < int'(list_len); i++) list_words[i-1] = list_words[i];
      list_len--;
    end
    res.entry_count = list_len[CntOutW-1:0];
    res.is_empty    = (list_len == 0);
    expected_results.push_back(res);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t want;
    list_result_t got;
    if (!rst_ni) begin
      list_len = 0;
      expected_results.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[41:0];
        if (expected_results.size() == 0) begin
          $display("[%0t] result %0d arrived with nothing expected", $realtime,
                   result_count_o);
          fail_count_o++;
        end else begin
          want = expected_results.pop_front();
          if (got.read_word !== want.read_word)
            report_mismatch("read_word", got.read_word, want.read_word);
          if (got.status !== want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
          if (got.entry_count !== want.entry_count)
            report_mismatch("entry_count", 32'(got.entry_count), 32'(want.entry_count));
          if (got.is_empty !== want.is_empty)
            report_mismatch("is_empty", 32'(got.is_empty), 32'(want.is_empty));
        end
        result_count_o++;
      end
      if (s_axis_tvalid && s_axis_tready)
        apply_list_request(req_e'(s_axis_tdata[1:0]), s_axis_tdata[8:2], s_axis_tdata[40:9]);
      pending_count_o = expected_results.size();
    end
  end

endmodule

>>> dv/tb.sv
// Testbench top for the positional list engine: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb;
  import ple_pkg::*;

  localparam int unsigned ListCap     = 64;
  localparam int          RandItems   = 550;
  localparam int          DrainCycles = 12;
  localparam int          LimitCycles = 400000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // req_type[1:0], position[8:2], word_in[40:9], zero fill
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // read_word[31:0], status[33:32], entry_count[40:34], is_empty[41], zero fill
  logic [OutDataW-1:0] m_axis_tdata;

  int fail_count;
  int pending_count;
  int result_count;
  int cycle_count = 0;

  int list_len_est = 0;
  int peak_len     = 0;
  int range_rejects = 0;
  int full_rejects  = 0;
  int sent_by_kind [4];

  int stall_mode = 0;
  int stall_left = 0;

  always #5 clk_i = ~clk_i;

  positional_list_engine_unit #(.CAPACITY(ListCap)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  ple_list_checker #(.CAPACITY(ListCap)) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .fail_count_o    (fail_count),
    .pending_count_o (pending_count),
    .result_count_o  (result_count)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LimitCycles) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Stall pattern: switch among always ready, mostly ready, mostly stalled and periodic.
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(3);
      stall_left = $urandom_range(80, 10);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(3) != 0);
      2: m_axis_tready <= ($urandom_range(3) == 0);
      default: m_axis_tready <= (cycle_count % 5 != 0);
    endcase
  end

  task automatic send_request(input req_e kind, input logic [PosW-1:0] pos,
                              input logic [WordW-1:0] word);
    int hi;
    hi = (kind == REQ_INSERT) ? list_len_est + 1 : list_len_est;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, word, pos, kind};
    do @(posedge clk_i); while (!s_axis_tready);
    sent_by_kind[kind]++;
    if (pos < 1 || pos > hi) begin
      range_rejects++;
    end else if (kind == REQ_INSERT) begin
      if (list_len_est >= ListCap) full_rejects++;
      else list_len_est++;
    end else if (kind == REQ_REMOVE) begin
      list_len_est--;
    end
    if (list_len_est > peak_len) peak_len = list_len_est;
    @(negedge clk_i);
  endtask

  initial begin
    int   burst_left;
    int   gap;
    int   phase;
    int   roll;
    int   hi;
    req_e kind;
    logic [PosW-1:0] pos;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Empty list: each of these requests is out of range.
    send_request(REQ_READ, 7'd1, 32'h0);
    send_request(REQ_READ, 7'd0, 32'h0);
    send_request(REQ_REMOVE, 7'd1, 32'h0);
    send_request(REQ_OVERWRITE, 7'd1, 32'hDEADBEEF);
    send_request(REQ_INSERT, 7'd0, 32'h1);
    send_request(REQ_INSERT, 7'd2, 32'h2);
    // Build front, back and middle; then read, overwrite and remove, in and out of range.
    send_request(REQ_INSERT, 7'd1, 32'h80000000);
    send_request(REQ_INSERT, 7'd2, 32'h7FFFFFFF);
    send_request(REQ_INSERT, 7'd2, 32'h00000000);
    send_request(REQ_INSERT, 7'd1, 32'hFFFFFFFF);
    send_request(REQ_READ, 7'd1, 32'h0);
    send_request(REQ_READ, 7'd2, 32'h0);
    send_request(REQ_READ, 7'd3, 32'h0);
    send_request(REQ_READ, 7'd4, 32'h0);
    send_request(REQ_READ, 7'd5, 32'h0);
    send_request(REQ_READ, 7'd127, 32'h0);
    send_request(REQ_OVERWRITE, 7'd3, 32'h12345678);
    send_request(REQ_OVERWRITE, 7'd5, 32'h55555555);
    send_request(REQ_REMOVE, 7'd5, 32'h0);
    send_request(REQ_REMOVE, 7'd4, 32'h0);
    send_request(REQ_REMOVE, 7'd1, 32'h0);
    send_request(REQ_REMOVE, 7'd127, 32'h0);
    send_request(REQ_READ, 7'd1, 32'h0);
    send_request(REQ_READ, 7'd2, 32'h0);

    // Alternate grow, mixed and drain phases so the list reaches full and empty.
    burst_left = 0;
    for (int n = 0; n < RandItems; n++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(24, 1);
        gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(4, 1);
        if (gap > 0) begin
          s_axis_tvalid <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end
      burst_left--;
      phase = (n / 110) % 4;
      roll  = $urandom_range(99);
      case (phase)
        0: kind = (roll < 80) ? REQ_INSERT : (roll < 85) ? REQ_REMOVE :
                  (roll < 95) ? REQ_READ : REQ_OVERWRITE;
        2: kind = (roll < 75) ? REQ_REMOVE : (roll < 82) ? REQ_INSERT :
                  (roll < 92) ? REQ_READ : REQ_OVERWRITE;
        default: kind = req_e'(roll % 4);
      endcase
      hi   = (kind == REQ_INSERT) ? list_len_est + 1 : list_len_est;
      roll = $urandom_range(9);
      if (roll == 0) pos = '0;
      else if (roll == 1 || hi == 0) pos = PosW'($urandom_range(127));
      else pos = PosW'($urandom_range(hi, 1));
      send_request(kind, pos, $urandom);
    end
    s_axis_tvalid <= 1'b0;

    wait (pending_count == 0);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d reads, %0d overwrites, %0d inserts, %0d removes; %0d results checked",
             sent_by_kind[REQ_READ], sent_by_kind[REQ_OVERWRITE], sent_by_kind[REQ_INSERT],
             sent_by_kind[REQ_REMOVE], result_count);
    $display("Out-of-range requests %0d, inserts into a full list %0d, peak length %0d",
             range_rejects, full_rejects, peak_len);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
